@@ hdl/bscd_pkg.sv @@
package bscd_pkg;

  // bus opcodes
  localparam logic [7:0] OP_AA = 8'hAA;
  localparam logic [7:0] OP_AB = 8'hAB;
  localparam logic [7:0] OP_AC = 8'hAC;
  localparam logic [7:0] OP_AD = 8'hAD;
  localparam logic [7:0] OP_AE = 8'hAE;
  localparam logic [7:0] OP_AF = 8'hAF;
  localparam logic [7:0] OP_SAMPLE_OFF = 8'hBA;
  localparam logic [7:0] OP_SAMPLE_ON  = 8'hBB;
  localparam logic [7:0] OP_BC = 8'hBC;
  localparam logic [7:0] OP_BD = 8'hBD;
  localparam logic [7:0] OP_BE = 8'hBE;
  localparam logic [7:0] OP_BIAS_CAL = 8'hBF;

  // command codes on the result port
  localparam logic [3:0] CMD_NONE       = 4'd0;
  localparam logic [3:0] CMD_AA         = 4'd1;
  localparam logic [3:0] CMD_AB         = 4'd2;
  localparam logic [3:0] CMD_AC         = 4'd3;
  localparam logic [3:0] CMD_AD         = 4'd4;
  localparam logic [3:0] CMD_AE         = 4'd5;
  localparam logic [3:0] CMD_AF         = 4'd6;
  localparam logic [3:0] CMD_SAMPLE_OFF = 4'd7;
  localparam logic [3:0] CMD_SAMPLE_ON  = 4'd8;
  localparam logic [3:0] CMD_BC         = 4'd9;
  localparam logic [3:0] CMD_BD         = 4'd10;
  localparam logic [3:0] CMD_BE         = 4'd11;
  localparam logic [3:0] CMD_BIAS_CAL   = 4'd12;

  // raw action codes of an input item
  localparam logic [2:0] ACTION_RX      = 3'd0;
  localparam logic [2:0] ACTION_READ    = 3'd1;
  localparam logic [2:0] ACTION_STOP    = 3'd2;
  localparam logic [2:0] ACTION_TIMEOUT = 3'd3;
  localparam logic [2:0] ACTION_LOAD    = 3'd4;

  // entries of the front-to-back queue
  localparam int QUEUE_DEPTH = 2;

  // receive entries that decode ever looks at: opcode and two bias bytes
  localparam int RX_KEEP = 3;

  typedef enum logic [2:0] {
    KIND_RX,
    KIND_READ,
    KIND_CLEAR,
    KIND_LOAD,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic       burst_end;
    logic [3:0] load_index;
  } bscd_in_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [15:0] bias_target;
    logic        sample_enable;
    logic [7:0]  read_data;
    logic        rx_overflow;
  } bscd_out_t;

  // classified item passed from front to back
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic       burst_end;
    logic [3:0] load_index;
    logic       load_ok;
  } cls_item_t;

  function automatic logic [3:0] opcode_cmd(input logic [7:0] op);
    logic [3:0] cmd;
    unique case (op)
      OP_AA:         cmd = CMD_AA;
      OP_AB:         cmd = CMD_AB;
      OP_AC:         cmd = CMD_AC;
      OP_AD:         cmd = CMD_AD;
      OP_AE:         cmd = CMD_AE;
      OP_AF:         cmd = CMD_AF;
      OP_SAMPLE_OFF: cmd = CMD_SAMPLE_OFF;
      OP_SAMPLE_ON:  cmd = CMD_SAMPLE_ON;
      OP_BC:         cmd = CMD_BC;
      OP_BD:         cmd = CMD_BD;
      OP_BE:         cmd = CMD_BE;
      OP_BIAS_CAL:   cmd = CMD_BIAS_CAL;
      default:       cmd = CMD_NONE;
    endcase
    return cmd;
  endfunction

endpackage

@@ hdl/bus_slave_command_decoder.sv @@
// Slave-side command engine of a two-wire bus. Each input item is one bus
// event (received byte, read request, stop, timeout, or a firmware load into
// the transmit store) and yields exactly one result item, in order. Throughput
// is one item per clock while the result side does not stall: the execution
// stage retires one event per cycle, updating the receive count, the first
// three receive bytes, the transmit pointer and the sampling flag, and issuing
// at most one access to the transmit store RAM. An accepted item is written
// into the two-entry front queue, and is taken from it and registered into
// the result register once that register is free or being popped. The front
// queue absorbs stalls on the result side; full rises once both entries are
// held.
module bus_slave_command_decoder
  import bscd_pkg::*;
#(
  parameter int RX_DEPTH = 8,
  parameter int TX_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  bscd_in_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output bscd_out_t out_data
);

  logic      q_push;
  cls_item_t q_item;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  cls_item_t q_head;

  bscd_front #(
    .TX_DEPTH (TX_DEPTH)
  ) u_front (
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_item)
  );

  bscd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  bscd_back #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

@@ hdl/bscd_ram.sv @@
module bscd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/bscd_front.sv @@
module bscd_front
  import bscd_pkg::*;
#(
  parameter int TX_DEPTH = 16
) (
  input  logic      in_push,
  input  bscd_in_t  in_data,
  output logic      in_full,
  input  logic      q_full,
  output logic      q_push,
  output cls_item_t q_item
);

  localparam logic [4:0] TX_LIMIT = (TX_DEPTH > 16) ? 5'd16 : 5'(TX_DEPTH);

  kind_t kind;

  always_comb begin
    unique case (in_data.action) inside
      ACTION_RX:      kind = KIND_RX;
      ACTION_READ:    kind = KIND_READ;
      ACTION_STOP,
      ACTION_TIMEOUT: kind = KIND_CLEAR;
      ACTION_LOAD:    kind = KIND_LOAD;
      default:        kind = KIND_NOP;
    endcase
  end

  assign q_item.kind       = kind;
  assign q_item.data_byte  = in_data.data_byte;
  assign q_item.burst_end  = in_data.burst_end;
  assign q_item.load_index = in_data.load_index;
  // loads beyond the transmit store are dropped
  assign q_item.load_ok    = ({1'b0, in_data.load_index} < TX_LIMIT);

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

endmodule

@@ hdl/bscd_queue.sv @@
module bscd_queue
  import bscd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output cls_item_t head
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QW-1:0] LAST = QW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  cls_item_t     mem_r [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_pop;

  assign full   = (cnt_r == FULL_CNT);
  assign valid  = (cnt_r != '0);
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hdl/bscd_back.sv @@
module bscd_back
  import bscd_pkg::*;
#(
  parameter int RX_DEPTH = 8,
  parameter int TX_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cls_item_t q_head,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output bscd_out_t out_data
);

  localparam int RCW = $clog2(RX_DEPTH + 1);
  localparam int TXW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [RCW-1:0] RX_FULL = RCW'(RX_DEPTH);
  localparam logic [RCW-1:0] RX_KEEP_CNT = RCW'(RX_KEEP);
  localparam logic [TXW-1:0] TX_LAST = TXW'(TX_DEPTH - 1);

  // only the first entries of the receive store are ever read back
  logic [7:0]     rx_r [RX_KEEP];
  logic [7:0]     rx_nxt [RX_KEEP];
  logic [RCW-1:0] cnt_r, cnt_nxt;
  logic [TXW-1:0] ptr_r, ptr_nxt;
  logic           samp_r, samp_nxt;
  logic           tx_vld_r [TX_DEPTH];

  logic           out_valid_r, out_valid_nxt;
  bscd_out_t      res_r, res_nxt;
  logic           rd_sel_r, rd_sel_nxt;

  logic           advance;
  logic           take;
  logic [3:0]     cmd;
  logic           ram_we;
  logic [TXW-1:0] ram_waddr;
  logic           ram_re;
  logic [7:0]     ram_rdata;

  assign advance = !out_valid_r || out_pop;
  assign take    = q_valid && advance;
  assign q_pop   = take;
  assign ram_waddr = TXW'(q_head.load_index);

  always_comb begin
    rx_nxt        = rx_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    samp_nxt      = samp_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    cmd           = CMD_NONE;
    res_nxt       = res_r;
    rd_sel_nxt    = rd_sel_r;
    out_valid_nxt = out_valid_r && !out_pop;

    if (take) begin
      res_nxt    = '0;
      rd_sel_nxt = 1'b0;
      case (q_head.kind)
        KIND_RX: begin
          if (cnt_r < RX_FULL) begin
            if (cnt_r < RX_KEEP_CNT) begin
              rx_nxt[cnt_r[1:0]] = q_head.data_byte;
            end
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            cnt_nxt = '0;
            res_nxt.rx_overflow = 1'b1;
          end
          if (q_head.burst_end) begin
            cmd = opcode_cmd(rx_nxt[0]);
            res_nxt.command = cmd;
            if (cmd == CMD_BIAS_CAL) begin
              res_nxt.bias_target = {rx_nxt[1], rx_nxt[2]};
              cnt_nxt = '0;
            end else if (cmd == CMD_NONE) begin
              cnt_nxt = '0;
            end else if (cmd == CMD_SAMPLE_OFF) begin
              samp_nxt = 1'b0;
            end else if (cmd == CMD_SAMPLE_ON) begin
              samp_nxt = 1'b1;
            end
          end
        end
        KIND_READ: begin
          ram_re     = 1'b1;
          rd_sel_nxt = tx_vld_r[ptr_r];
          ptr_nxt    = (ptr_r == TX_LAST) ? '0 : ptr_r + 1'b1;
        end
        KIND_CLEAR: begin
          cnt_nxt = '0;
        end
        KIND_LOAD: begin
          ram_we = q_head.load_ok;
        end
        default: begin
        end
      endcase
      res_nxt.sample_enable = samp_nxt;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RX_KEEP; i++) begin
        rx_r[i] <= '0;
      end
      for (int i = 0; i < TX_DEPTH; i++) begin
        tx_vld_r[i] <= 1'b0;
      end
      cnt_r       <= '0;
      ptr_r       <= '0;
      samp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rx_r        <= rx_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      samp_r      <= samp_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        tx_vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    rd_sel_r <= rd_sel_nxt;
  end

  // transmit store; an entry never loaded reads as zero
  bscd_ram #(
    .WIDTH (8),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_head.data_byte),
    .re    (ram_re),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_data           = res_r;
    out_data.read_data = rd_sel_r ? ram_rdata : 8'h00;
  end

  assign out_empty = !out_valid_r;

endmodule
